/* rtl/core/oid_arc_decoder_unit_assert.svh */
// Assertion macros for the OID arc decoder; all sample on clk and are off in reset.
`ifndef OID_ARC_DECODER_UNIT_ASSERT_SVH
`define OID_ARC_DECODER_UNIT_ASSERT_SVH

// cond must hold at every edge out of reset
`define OIDD_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// when trig holds, cond holds at the same edge
`define OIDD_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// when trig holds, cond holds at the next edge
`define OIDD_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

/* rtl/core/oidd_pkg.sv */
package oidd_pkg;

  localparam int unsigned OID_DIVISOR = 40;
  // floor(b / 40) == (b * 205) >> 13 for every 8-bit b
  localparam int unsigned DIV_RECIP   = 205;
  localparam int unsigned DIV_SHIFT   = 13;
  localparam logic [7:0]  PAYLOAD_MASK = 8'h7F;
  localparam logic [7:0]  CONT_BIT     = 8'h80;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [31:0] arc_value;
    logic        arc_last;
    logic [1:0]  status;
  } out_t;

  // write side of the result queue
  typedef struct packed {
    logic [1:0] push_cnt;
  } q_ctrl_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
    logic               room2;
  } q_stat_t;

  function automatic logic [7:0] div40(input logic [7:0] b);
    logic [15:0] p;
    p = 16'(b) * 16'(DIV_RECIP);
    return 8'(p >> DIV_SHIFT);
  endfunction

  function automatic logic [7:0] mod40(input logic [7:0] b);
    logic [7:0] q;
    q = div40(b);
    return b - 8'(q * 8'(OID_DIVISOR));
  endfunction

endpackage

/* rtl/core/oid_arc_decoder_unit.sv */
// OID arc decoder: takes BER object identifier content bytes, one per transaction, with
// in_last on the final byte, and returns arc numbers. One byte is accepted every cycle
// while the four-entry result queue has room for two results; the first byte of an
// identifier gives two results and each later byte gives at most one, and the queue
// hands out one result per cycle while out_ready is high, so with out_ready high
// the input sustains one byte per cycle except after first bytes, whose extra
// result can stall input. Results pass the input register, then the result queue.
`include "oid_arc_decoder_unit_assert.svh"

module oid_arc_decoder_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  oidd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output oidd_pkg::out_t out_data
);

  // input register
  logic          s_valid;
  oidd_pkg::in_t s_item;

  // decoder state
  logic        at_start;
  logic [31:0] accumulator;
  logic        overflowed;

  logic        at_start_next;
  logic [31:0] accumulator_next;
  logic        overflowed_next;

  logic        stage_move;
  logic        ovf_now;
  logic [31:0] acc_shift;
  logic        cont;

  oidd_pkg::q_ctrl_t q_ctrl;
  oidd_pkg::q_stat_t q_stat;
  oidd_pkg::out_t    r0;
  oidd_pkg::out_t    r1;

  assign stage_move = s_valid && q_stat.room2;
  assign in_ready   = !s_valid || q_stat.room2;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s_valid <= 1'b1;
    end else if (stage_move) begin
      s_valid <= 1'b0;
    end
  end

  assign cont      = s_item.in_byte[7];
  assign ovf_now   = overflowed || (accumulator[31:25] != 7'd0);
  assign acc_shift = {accumulator[24:0], s_item.in_byte[6:0]};

  always_comb begin
    r0               = '0;
    r1               = '0;
    q_ctrl.push_cnt  = 2'd0;
    at_start_next    = at_start;
    accumulator_next = accumulator;
    overflowed_next  = overflowed;
    if (at_start) begin
      r0.arc_value     = {24'd0, oidd_pkg::div40(s_item.in_byte)};
      r0.arc_last      = 1'b0;
      r0.status        = oidd_pkg::ST_OK;
      r1.arc_value     = {24'd0, oidd_pkg::mod40(s_item.in_byte)};
      r1.arc_last      = s_item.in_last;
      r1.status        = oidd_pkg::ST_OK;
      q_ctrl.push_cnt  = 2'd2;
      at_start_next    = s_item.in_last;
      accumulator_next = '0;
      overflowed_next  = 1'b0;
    end else if (!cont) begin
      r0.arc_value     = acc_shift;
      r0.arc_last      = s_item.in_last;
      r0.status        = ovf_now ? oidd_pkg::ST_OVERFLOW : oidd_pkg::ST_OK;
      q_ctrl.push_cnt  = 2'd1;
      at_start_next    = s_item.in_last;
      accumulator_next = '0;
      overflowed_next  = 1'b0;
    end else if (s_item.in_last) begin
      // open arc cut off by the final byte; truncation wins over overflow
      r0.arc_value     = acc_shift;
      r0.arc_last      = 1'b1;
      r0.status        = oidd_pkg::ST_TRUNC;
      q_ctrl.push_cnt  = 2'd1;
      at_start_next    = 1'b1;
      accumulator_next = '0;
      overflowed_next  = 1'b0;
    end else begin
      accumulator_next = acc_shift;
      overflowed_next  = ovf_now;
    end
    if (!stage_move) begin
      q_ctrl.push_cnt  = 2'd0;
      at_start_next    = at_start;
      accumulator_next = accumulator;
      overflowed_next  = overflowed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start    <= 1'b1;
      accumulator <= '0;
      overflowed  <= 1'b0;
    end else begin
      at_start    <= at_start_next;
      accumulator <= accumulator_next;
      overflowed  <= overflowed_next;
    end
  end

  oidd_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (q_ctrl),
    .wdata0    (r0),
    .wdata1    (r1),
    .stat      (q_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `OIDD_ALWAYS(a_q_bound, q_stat.count <= oidd_pkg::Q_CNT_W'(oidd_pkg::Q_DEPTH), "result queue overrun")
  `OIDD_SAME(a_first_two, stage_move && at_start, q_ctrl.push_cnt == 2'd2, "first byte must push two arcs")
  `OIDD_NEXT(a_last_restart, stage_move && s_item.in_last, at_start && accumulator == 32'd0, "no restart after last byte")

endmodule

/* rtl/core/oidd_result_fifo.sv */
module oidd_result_fifo (
  input  logic            clk,
  input  logic            rst,
  input  oidd_pkg::q_ctrl_t ctrl,
  input  oidd_pkg::out_t  wdata0,
  input  oidd_pkg::out_t  wdata1,
  output oidd_pkg::q_stat_t stat,
  output logic            out_valid,
  input  logic            out_ready,
  output oidd_pkg::out_t  out_data
);

  oidd_pkg::out_t mem [oidd_pkg::Q_DEPTH];
  logic [oidd_pkg::Q_PTR_W-1:0] wptr;
  logic [oidd_pkg::Q_PTR_W-1:0] rptr;
  logic [oidd_pkg::Q_CNT_W-1:0] count;
  logic [oidd_pkg::Q_PTR_W-1:0] wptr1;
  logic pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data  = mem[rptr];
  assign wptr1     = wptr + 1'b1;

  assign stat.count = count;
  assign stat.room2 = (count <= oidd_pkg::Q_CNT_W'(oidd_pkg::Q_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (ctrl.push_cnt != 2'd0) begin
      mem[wptr] <= wdata0;
    end
    if (ctrl.push_cnt == 2'd2) begin
      mem[wptr1] <= wdata1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + oidd_pkg::Q_PTR_W'(ctrl.push_cnt);
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + oidd_pkg::Q_CNT_W'(ctrl.push_cnt) - oidd_pkg::Q_CNT_W'(pop);
    end
  end

endmodule
